[hdl/stfq_pkg.sv]
// Package with the shared constants, codes and types of the shared task queue.
`timescale 1ns / 1ps

package stfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int TASK_BITS_DEF   = 32;
    localparam int MAX_ROOM_DEF    = 64;

    localparam int OPC_W  = 2;
    localparam int WORD_W = 32;
    localparam int ROOM_W = 7;
    localparam int WCNT_W = 7;
    localparam int STAT_W = 2;

    localparam logic [OPC_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OPC_W-1:0] OP_POP   = 2'd1;
    localparam logic [OPC_W-1:0] OP_BATCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_DELIVERED = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE      = 2'd1;
    localparam logic [STAT_W-1:0] ST_PUSHED    = 2'd2;
    localparam logic [STAT_W-1:0] ST_DROPPED   = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_READ = 5'b00100,
        S_EMIT = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

endpackage

[hdl/stfq_div.sv]
// Iterative restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module stfq_div
    import stfq_pkg::*;
#(
    parameter int NUM_W = 9,
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;

    always_comb begin
        shifted = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!diff[DEN_W+1]) begin
                r_rem <= diff[DEN_W:0];
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[hdl/stfq_store.sv]
// Circular task memory with head, tail and fill count.
`timescale 1ns / 1ps

module stfq_store
    import stfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TASK_BITS   = TASK_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic [TASK_BITS-1:0]               i_push_data,
    input  logic                               i_pop,
    output logic [TASK_BITS-1:0]               o_pop_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_fill
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    logic [TASK_BITS-1:0] mem [QUEUE_DEPTH];
    logic [TASK_BITS-1:0] r_rd_data;
    logic [AW-1:0]        r_head;
    logic [AW-1:0]        r_tail;
    logic [FW-1:0]        r_fill;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_tail] <= i_push_data;
        end
        if (i_pop) begin
            r_rd_data <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
            end
            if (i_pop) begin
                r_head <= (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FW'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - FW'(1);
            end
        end
    end

    assign o_pop_data = r_rd_data;
    assign o_fill     = r_fill;

endmodule

[hdl/shared_task_fifo_with_batch_share.sv]
// Top level of the shared task queue with fair-share batch pop.
`timescale 1ns / 1ps

// The block takes one request word at a time and answers it on the output
// stream. The input is not ready again until the last response word of a
// request has been loaded into the output register. A push, a dropped push
// and any request answered with none go through the response state, which
// loads their response word into the output register. A single pop reads the
// task memory, whose read data is registered, and then loads the word into
// the output register. A batch pop first divides the fill count by the worker
// count in an iterative divider. The divider produces one quotient bit per
// cycle, 9 bits at the default depth, and registers its done flag with the
// last bit. The block then hands out the share, the quotient clamped to at
// least one and at most the clamped room, one task at a time, each as a
// memory read followed by loading the output register. The next request can
// be accepted as soon as a request's last word is presented. A stalled output
// adds its wait.
module shared_task_fifo_with_batch_share
    import stfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TASK_BITS   = TASK_BITS_DEF,
    parameter int MAX_ROOM    = MAX_ROOM_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WCNT_W-1:0] i_cfg_wdata,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [39:0]       i_s_tdata,   // task_word [31:0], room [38:32]
    input  logic [OPC_W-1:0]  i_s_tuser,   // opcode
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [WORD_W-1:0] o_m_tdata,   // out_task
    output logic [STAT_W-1:0] o_m_tuser,   // status
    output logic              o_m_tlast
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = $clog2(MAX_ROOM + 1);
    localparam int CW = (FW > RW) ? FW : RW;
    localparam logic [ROOM_W-1:0] MAX_ROOM_IN = ROOM_W'(MAX_ROOM);
    localparam logic [FW-1:0]     FULL_FILL   = FW'(QUEUE_DEPTH);

    t_state              r_state, n_state;
    logic [WCNT_W-1:0]   r_workers;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [RW-1:0]       r_room, n_room;
    logic [RW-1:0]       r_left, n_left;
    logic                r_out_valid, n_out_valid;
    logic [WORD_W-1:0]   r_out_task, n_out_task;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic                r_out_last, n_out_last;

    logic                accept;
    logic                out_free;
    logic                push;
    logic                pop;
    logic                div_start;
    logic                div_done;
    logic [FW-1:0]       quo;
    logic [FW-1:0]       fill;
    logic [TASK_BITS-1:0] pop_data;
    logic [WCNT_W-1:0]   divisor;
    logic [OPC_W-1:0]    opcode;
    logic [WORD_W-1:0]   task_word;
    logic [ROOM_W-1:0]   room_in;
    logic [RW-1:0]       room_clamped;
    logic [CW-1:0]       quo_min1;

    assign opcode    = i_s_tuser;
    assign task_word = i_s_tdata[31:0];
    assign room_in   = i_s_tdata[38:32];
    assign room_clamped = (room_in > MAX_ROOM_IN) ? RW'(MAX_ROOM) : RW'(room_in);
    assign divisor   = (r_workers == '0) ? WCNT_W'(1) : r_workers;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign quo_min1   = (quo == '0) ? CW'(1) : CW'(quo);

    stfq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TASK_BITS   (TASK_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (TASK_BITS'(task_word)),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_fill      (fill)
    );

    stfq_div #(
        .NUM_W (FW),
        .DEN_W (WCNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (fill),
        .i_den   (divisor),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_room       = r_room;
        n_left       = r_left;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_task   = r_out_task;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        push         = 1'b0;
        pop          = 1'b0;
        div_start    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state  = S_RESP;
                    n_status = ST_NONE;
                    case (opcode)
                        OP_PUSH: begin
                            if (fill == FULL_FILL) begin
                                n_status = ST_DROPPED;
                            end else begin
                                push     = 1'b1;
                                n_status = ST_PUSHED;
                            end
                        end
                        OP_POP: begin
                            if (fill != '0) begin
                                n_left  = RW'(1);
                                n_state = S_READ;
                            end
                        end
                        OP_BATCH: begin
                            if (fill != '0 && room_clamped != '0) begin
                                n_room    = room_clamped;
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        default: begin
                            n_status = ST_NONE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_left  = (quo_min1 > CW'(r_room)) ? r_room : RW'(quo_min1);
                    n_state = S_READ;
                end
            end
            S_READ: begin
                pop     = 1'b1;
                n_left  = r_left - RW'(1);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_task   = WORD_W'(pop_data);
                    n_out_status = ST_DELIVERED;
                    n_out_last   = (r_left == '0);
                    n_state      = (r_left == '0) ? S_IDLE : S_READ;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_task   = '0;
                    n_out_status = r_status;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_workers   <= WCNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_workers <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_room       <= n_room;
        r_left       <= n_left;
        r_out_task   <= n_out_task;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_task;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

[hdl/stfq_chk.sv]
// Port-level checker for the shared task queue and its bind to the top level.
`timescale 1ns / 1ps

module stfq_chk
    import stfq_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [WORD_W-1:0] o_m_tdata,
    input logic [STAT_W-1:0] o_m_tuser,
    input logic              o_m_tlast
);

    // A stalled output word keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // Every word that does not deliver a task is a single, zero-valued answer.
    a_no_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_DELIVERED |-> o_m_tdata == '0 && o_m_tlast)
        else $error("non-delivery word carries a task or is not last");

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while another is in progress");

    // Reset leaves the output empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind shared_task_fifo_with_batch_share stfq_chk u_stfq_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
